// ===== rtl/core/afr_pkg.sv =====
`default_nettype none

package afr_pkg;

    // frame delimiters and codes
    localparam logic [7:0] START_BYTE     = 8'h7E;
    localparam logic [7:0] TX_STATUS_TYPE = 8'h8B;
    localparam logic [7:0] CHECK_BASE     = 8'hFF;
    localparam logic [7:0] DELIVERY_OK    = 8'h00;

    // data byte position of the delivery status, counted from zero
    localparam logic [15:0] STATUS_INDEX  = 16'd5;
    localparam logic [15:0] TX_STATUS_MIN = 16'd6;

    localparam logic [15:0] MAX_LEN_RESET = 16'd127;

    typedef enum logic [1:0] {
        OUTCOME_GOOD     = 2'd0,
        OUTCOME_BAD_SUM  = 2'd1,
        OUTCOME_TOO_LONG = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  type_code;
        logic [15:0] data_length;
        logic        is_tx_status;
        logic [7:0]  status_code;
        logic        delivered;
    } t_result;

    // handshake between the parser and the result register
    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/afr_byte_if.sv =====
`default_nettype none

interface afr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/afr_result_if.sv =====
`default_nettype none

interface afr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [7:0]  type_code;
    logic [15:0] data_length;
    logic        is_tx_status;
    logic [7:0]  status_code;
    logic        delivered;

    modport source (
        output valid, output outcome, output type_code, output data_length,
        output is_tx_status, output status_code, output delivered,
        input ready
    );
    modport sink (
        input valid, input outcome, input type_code, input data_length,
        input is_tx_status, input status_code, input delivered,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/afr_parser.sv =====
`default_nettype none

module afr_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_byte_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic [15:0]     i_max_len,
    input  wire logic            i_out_free,
    output logic                 o_take,
    output afr_pkg::t_push       o_push
);

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_decl_len, n_decl_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_status, n_status;

    logic        has_result;
    logic [15:0] full_len;
    logic [7:0]  expect_sum;
    logic        tx_status;
    afr_pkg::t_result res;

    assign full_len   = {r_decl_len[15:8], i_byte};
    assign expect_sum = afr_pkg::CHECK_BASE - r_sum;
    assign tx_status  = (r_type == afr_pkg::TX_STATUS_TYPE) &&
                        (r_decl_len >= afr_pkg::TX_STATUS_MIN);

    // result formation for the current byte
    always_comb begin
        has_result       = 1'b0;
        res.outcome      = afr_pkg::OUTCOME_GOOD;
        res.type_code    = r_type;
        res.data_length  = r_decl_len;
        res.is_tx_status = 1'b0;
        res.status_code  = 8'h00;
        res.delivered    = 1'b0;
        case (r_phase)
            PH_LEN_LO: begin
                if (full_len > i_max_len) begin
                    has_result      = 1'b1;
                    res.outcome     = afr_pkg::OUTCOME_TOO_LONG;
                    res.type_code   = 8'h00;
                    res.data_length = full_len;
                end
            end
            PH_DATA: begin
                if (r_seen == r_decl_len) begin
                    has_result = 1'b1;
                    if (expect_sum != i_byte) begin
                        res.outcome = afr_pkg::OUTCOME_BAD_SUM;
                    end else begin
                        res.is_tx_status = tx_status;
                        res.status_code  = tx_status ? r_status : 8'h00;
                        res.delivered    = tx_status &&
                                           (r_status == afr_pkg::DELIVERY_OK);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // byte is consumed unless its result cannot be stored
    assign o_take          = i_byte_valid && (!has_result || i_out_free);
    assign o_push.push     = o_take && has_result;
    assign o_push.res      = res;

    // next frame state
    always_comb begin
        n_phase    = r_phase;
        n_decl_len = r_decl_len;
        n_seen     = r_seen;
        n_sum      = r_sum;
        n_type     = r_type;
        n_status   = r_status;
        case (r_phase)
            PH_WAIT: begin
                if (i_byte == afr_pkg::START_BYTE) begin
                    n_decl_len = 16'h0000;
                    n_seen     = 16'h0000;
                    n_sum      = 8'h00;
                    n_type     = 8'h00;
                    n_status   = 8'h00;
                    n_phase    = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_decl_len = {i_byte, 8'h00};
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_decl_len = full_len;
                n_phase    = has_result ? PH_WAIT : PH_DATA;
            end
            PH_DATA: begin
                if (has_result) begin
                    n_phase = PH_WAIT;
                end else begin
                    if (r_seen == 16'h0000) begin
                        n_type = i_byte;
                    end
                    if (r_seen == afr_pkg::STATUS_INDEX) begin
                        n_status = i_byte;
                    end
                    n_sum  = r_sum + i_byte;
                    n_seen = r_seen + 16'd1;
                end
            end
            default: begin
                n_phase = PH_WAIT;
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_decl_len <= 16'h0000;
            r_seen     <= 16'h0000;
            r_sum      <= 8'h00;
            r_type     <= 8'h00;
            r_status   <= 8'h00;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_decl_len <= n_decl_len;
            r_seen     <= n_seen;
            r_sum      <= n_sum;
            r_type     <= n_type;
            r_status   <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/afr_out_reg.sv =====
`default_nettype none

module afr_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire afr_pkg::t_push  i_push,
    output logic                 o_free,
    afr_result_if.source         o_res
);

    logic             r_valid;
    afr_pkg::t_result r_res;

    // slot can take a result when empty or emptied this cycle
    assign o_free = !r_valid || o_res.ready;

    // result holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_res <= i_push.res;
        end
    end

    // drive the output channel
    assign o_res.valid        = r_valid;
    assign o_res.outcome      = r_res.outcome;
    assign o_res.type_code    = r_res.type_code;
    assign o_res.data_length  = r_res.data_length;
    assign o_res.is_tx_status = r_res.is_tx_status;
    assign o_res.status_code  = r_res.status_code;
    assign o_res.delivered    = r_res.delivered;

endmodule

`default_nettype wire

// ===== rtl/core/api_frame_receiver.sv =====
`default_nettype none

// Byte-serial receiver for start-delimited API frames: it hunts for 0x7E, reads
// a big-endian 16-bit length, the data bytes and a checksum, and reports one
// result per frame (good, checksum mismatch, or length above max_frame_length,
// which drops the frame right after the length field). Bytes outside a frame
// other than 0x7E are ignored. One byte is accepted every clock cycle unless
// a byte that ends a frame waits for a full output slot; bytes pass an input
// register and the parser's state update, and the output register takes the
// result as the parser consumes the byte that ends the frame. A stalled output
// holds its result while the parser keeps consuming bytes that produce no result.
module api_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    afr_byte_if.sink         i_rx,
    afr_result_if.source     o_res
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic [15:0]    r_max_len;
    logic           take;
    logic           out_free;
    afr_pkg::t_push push;

    // max frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= afr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // input byte register
    assign i_rx.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    afr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .i_max_len    (r_max_len),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_push       (push)
    );

    afr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    import afr_pkg::*;

    localparam int ITEMS_TARGET = 1250;
    localparam int PHASE_ITEMS  = 120;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE       = 6;
    localparam int LONG_HOLD    = 300;

    localparam t_result NO_RESULT = '0;

    // parser phases of the local frame model
    typedef enum logic [1:0] {
        SEEK_START,
        GET_LEN_HI,
        GET_LEN_LO,
        GET_BODY
    } t_frm_phase;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    res;
    } t_dir_row;

    // expected results that can be read straight off the frame bytes
    localparam t_result RES_EMPTY_OK  = {OUTCOME_GOOD, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0};
    localparam t_result RES_LONG_128  = {OUTCOME_TOO_LONG, 8'h00, 16'h0080, 1'b0, 8'h00, 1'b0};
    localparam t_result RES_LONG_FFFF = {OUTCOME_TOO_LONG, 8'h00, 16'hFFFF, 1'b0, 8'h00, 1'b0};
    localparam t_result RES_BAD_SUM   = {OUTCOME_BAD_SUM, 8'h7E, 16'h0001, 1'b0, 8'h00, 1'b0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    afr_byte_if   rx_if ();
    afr_result_if res_if ();

    // typed expectation that travels with the byte on the input channel
    logic    cur_typed = 1'b0;
    t_result cur_res = '0;

    // local frame model state
    t_frm_phase  frm_phase = SEEK_START;
    logic [15:0] frm_len = '0;
    logic [15:0] frm_count = '0;
    logic [7:0]  frm_sum = '0;
    logic [7:0]  frm_type = '0;
    logic [7:0]  frm_status = '0;
    logic [15:0] len_limit = MAX_LEN_RESET;

    t_result expected_frames [$];
    int      frame_bytes = 0;
    int      err_count = 0;
    bit      gaps_on = 1'b1;
    bit      long_hold = 1'b0;

    // directed frames: empty, too long, transmit status, bad checksum
    t_dir_row dir_rows [0:24] = '{
        {8'h7E, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'hFF, 1'b1, RES_EMPTY_OK},
        {8'h7E, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h80, 1'b1, RES_LONG_128},
        {8'h7E, 1'b0, NO_RESULT}, {8'hFF, 1'b0, NO_RESULT},
        {8'hFF, 1'b1, RES_LONG_FFFF},
        {8'h7E, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT}, {8'h06, 1'b0, NO_RESULT},
        {8'h8B, 1'b0, NO_RESULT}, {8'h01, 1'b0, NO_RESULT}, {8'h02, 1'b0, NO_RESULT},
        {8'h03, 1'b0, NO_RESULT}, {8'h04, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT},
        {8'h6A, 1'b0, NO_RESULT},
        {8'h7E, 1'b0, NO_RESULT}, {8'h00, 1'b0, NO_RESULT}, {8'h01, 1'b0, NO_RESULT},
        {8'h7E, 1'b0, NO_RESULT},
        {8'h00, 1'b1, RES_BAD_SUM}
    };

    api_frame_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    always #6 clk = ~clk;

    // frame model: one received byte in, at most one frame result out
    function automatic bit deframe_byte(input logic [7:0] b, output t_result res);
        logic [7:0] want_sum;
        bit         txs;
        res = '0;
        deframe_byte = 1'b0;
        case (frm_phase)
            SEEK_START: begin
                if (b == START_BYTE) begin
                    frm_len    = '0;
                    frm_count  = '0;
                    frm_sum    = '0;
                    frm_type   = '0;
                    frm_status = '0;
                    frm_phase  = GET_LEN_HI;
                end
            end
            GET_LEN_HI: begin
                frm_len   = {b, 8'h00};
                frm_phase = GET_LEN_LO;
            end
            GET_LEN_LO: begin
                frm_len[7:0] = b;
                if (frm_len > len_limit) begin
                    frm_phase       = SEEK_START;
                    res.outcome     = OUTCOME_TOO_LONG;
                    res.data_length = frm_len;
                    deframe_byte    = 1'b1;
                end else begin
                    frm_phase = GET_BODY;
                end
            end
            default: begin
                if (frm_count < frm_len) begin
                    if (frm_count == 16'd0)
                        frm_type = b;
                    if (frm_count == STATUS_INDEX)
                        frm_status = b;
                    frm_sum   = frm_sum + b;
                    frm_count = frm_count + 16'd1;
                end else begin
                    // checksum byte closes the frame
                    want_sum        = CHECK_BASE - frm_sum;
                    frm_phase       = SEEK_START;
                    res.type_code   = frm_type;
                    res.data_length = frm_len;
                    deframe_byte    = 1'b1;
                    if (want_sum != b) begin
                        res.outcome = OUTCOME_BAD_SUM;
                    end else begin
                        txs = (frm_type == TX_STATUS_TYPE) && (frm_len >= TX_STATUS_MIN);
                        res.outcome      = OUTCOME_GOOD;
                        res.is_tx_status = txs;
                        res.status_code  = txs ? frm_status : 8'h00;
                        res.delivered    = txs && (frm_status == DELIVERY_OK);
                    end
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // result check first, then byte prediction
    always @(posedge clk) begin : check_and_predict
        t_result got;
        t_result want;
        t_result predicted;
        bit      produced;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = {res_if.outcome, res_if.type_code, res_if.data_length,
                       res_if.is_tx_status, res_if.status_code, res_if.delivered};
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end else begin
                    want = expected_frames.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, want %0d",
                                                  got.outcome, want.outcome));
                    if (got.type_code !== want.type_code)
                        report_mismatch($sformatf("type_code %h, want %h",
                                                  got.type_code, want.type_code));
                    if (got.data_length !== want.data_length)
                        report_mismatch($sformatf("data_length %h, want %h",
                                                  got.data_length, want.data_length));
                    if (got.is_tx_status !== want.is_tx_status)
                        report_mismatch($sformatf("is_tx_status %b, want %b",
                                                  got.is_tx_status, want.is_tx_status));
                    if (got.status_code !== want.status_code)
                        report_mismatch($sformatf("status_code %h, want %h",
                                                  got.status_code, want.status_code));
                    if (got.delivered !== want.delivered)
                        report_mismatch($sformatf("delivered %b, want %b",
                                                  got.delivered, want.delivered));
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                if (frm_phase != SEEK_START || rx_if.rx_byte == START_BYTE)
                    frame_bytes++;
                produced = deframe_byte(rx_if.rx_byte, predicted);
                if (cur_typed)
                    expected_frames.push_back(cur_res);
                else if (produced)
                    expected_frames.push_back(predicted);
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            res_if.ready = 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result res);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            rx_if.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        cur_typed     = typed;
        cur_res       = res;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending until every expected result is back and the pipe is empty
    task automatic drain();
        rx_if.valid = 1'b0;
        cur_typed   = 1'b0;
        while (expected_frames.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        len_limit = v;
    endtask

    // mostly well-formed frames with random content, some noise and cut frames
    task automatic send_frame();
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  data;
        logic [7:0]  chk;
        int          pick;
        int          cut;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = 16'($urandom_range(0, 12));
        else if (pick < 72)
            len = (len_limit <= 16'd64) ? len_limit : 16'($urandom_range(0, 12));
        else if (pick < 84)
            len = (len_limit < 16'hFFFF) ? len_limit + 16'd1 : TX_STATUS_MIN;
        else if (pick < 86)
            len = (len_limit >= 16'd300) ? 16'd300 : TX_STATUS_MIN;
        else begin
            len = 16'($urandom);
            if (len <= len_limit && len > 16'd64)
                len = {12'h000, len[3:0]};
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : -1;
        send_byte(START_BYTE, 1'b0, NO_RESULT);
        send_byte(len[15:8], 1'b0, NO_RESULT);
        send_byte(len[7:0], 1'b0, NO_RESULT);
        if (len > len_limit)
            return;
        sum = '0;
        for (int i = 0; i < len; i++) begin
            if (i == cut)
                return;
            if (i == 0)
                data = $urandom_range(0, 1) ? TX_STATUS_TYPE : 8'($urandom_range(0, 255));
            else if (i == STATUS_INDEX)
                data = $urandom_range(0, 1) ? DELIVERY_OK : 8'($urandom_range(0, 255));
            else
                data = 8'($urandom_range(0, 255));
            send_byte(data, 1'b0, NO_RESULT);
            sum = sum + data;
        end
        chk = CHECK_BASE - sum;
        if ($urandom_range(0, 4) == 0)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk, 1'b0, NO_RESULT);
    endtask

    initial begin
        int          ph;
        int          stop_at;
        logic [15:0] lim;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames at the reset length limit
        for (int r = 0; r < 25; r++)
            send_byte(dir_rows[r].rx, dir_rows[r].typed, dir_rows[r].res);

        // random phases, each under its own length limit
        ph = 0;
        while (frame_bytes < ITEMS_TARGET) begin
            case (ph)
                0: lim = 16'h0000;
                1: lim = 16'hFFFF;
                2: lim = TX_STATUS_MIN;
                3: lim = STATUS_INDEX;
                default: lim = $urandom_range(0, 1) ? 16'($urandom_range(0, 24))
                                                    : 16'($urandom_range(0, 65535));
            endcase
            drain();
            write_max(lim);
            gaps_on = (frame_bytes + CALM_TAIL < ITEMS_TARGET) && (ph % 4 != 3);
            if (ph == 4)
                long_hold = 1'b1;
            stop_at = frame_bytes + PHASE_ITEMS;
            while (frame_bytes < stop_at && frame_bytes < ITEMS_TARGET)
                send_frame();
            ph++;
        end

        drain();
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/afr_pkg.sv
rtl/core/afr_byte_if.sv
rtl/core/afr_result_if.sv
rtl/core/afr_parser.sv
rtl/core/afr_out_reg.sv
rtl/core/api_frame_receiver.sv
dv/tb_top.sv
